[hw/rtl/lkvc_pkg.sv]
// ============================================================================
// lkvc_pkg : shared constants for the LRU key/value cache
// Field widths, request kinds, fixed result values and the capacity reset.
// ============================================================================
package lkvc_pkg;

    localparam int DATA_W = 32;
    localparam int CFG_W  = 5;

    // Request kinds carried on the kind field.
    typedef enum logic [0:0] {
        KIND_GET = 1'b0,
        KIND_PUT = 1'b1
    } kind_t;

    localparam logic [CFG_W-1:0]  CAP_RESET  = 5'd16;
    localparam logic [DATA_W-1:0] MISS_VALUE = 32'hFFFF_FFFF;
    localparam logic [DATA_W-1:0] PUT_VALUE  = 32'h0000_0000;

endpackage

[hw/rtl/lru_key_value_cache.sv]
// ============================================================================
// lru_key_value_cache : fully associative key/value cache with LRU replacement
// Gets and puts on 32-bit keys, ENTRIES slots, programmable capacity.
// ============================================================================
// Usage. Request words enter on the s_ channel (s_valid / s_ready): s_kind
// selects a get or a put, s_lookup_key is the key and s_store_value the value
// stored by a put. Every request produces exactly one result word on the m_
// channel (m_valid / m_ready): m_found tells whether the key was present, and
// m_read_value carries the stored value for a get hit, all ones for a get
// miss and zero for a put.
// After acceptance the request sits in the request register and moves into
// the result register, which drives m_valid, once that register is free.
// Throughput is one request per cycle while the receiver keeps m_ready high;
// the key compare across all slots, the recency rank update and the value
// memory write all complete as a request moves between the two registers,
// and the value for a get hit is read from the value memory at that move.
// The user must write the capacity register through cfg_wr_en / cfg_wr_data
// only while the block is idle; the block itself does not enforce this. Zero
// acts as one and values above ENTRIES act as ENTRIES.
// Reset (aresetn low, synchronous) empties the cache at once through the slot
// valid bits and restores capacity to 16; no clearing pass follows. When the
// receiver stalls, the result word holds and s_ready falls as soon as the
// request register is also occupied; no word is lost.
// ============================================================================
module lru_key_value_cache
    import lkvc_pkg::*;
#(
    parameter int ENTRIES = 16
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    // Configuration.
    input  logic                     cfg_wr_en,
    input  logic [CFG_W-1:0]         cfg_wr_data,
    // Request channel.
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic                     s_kind,
    input  logic signed [DATA_W-1:0] s_lookup_key,
    input  logic signed [DATA_W-1:0] s_store_value,
    // Result channel.
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic                     m_found,
    output logic signed [DATA_W-1:0] m_read_value
);

    // Slot index and rank widths; ranks run 0..ENTRIES-1.
    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int OCC_W = $clog2(ENTRIES + 1);
    // Width wide enough for the capacity register and for ENTRIES itself.
    localparam int CW    = (CFG_W > OCC_W) ? CFG_W : OCC_W;

    // ------------------------------------------------------------------
    // Capacity register and its clamped value.
    // ------------------------------------------------------------------
    logic [CFG_W-1:0] cap_reg;
    logic [CW-1:0]    cap_ext;
    logic [CW-1:0]    eff_cap;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= CAP_RESET;
        end else if (cfg_wr_en) begin
            cap_reg <= cfg_wr_data;
        end
    end

    assign cap_ext = CW'(cap_reg);

    always_comb begin
        priority if (cap_ext == '0) begin
            eff_cap = CW'(1);
        end else if (cap_ext > CW'(ENTRIES)) begin
            eff_cap = CW'(ENTRIES);
        end else begin
            eff_cap = cap_ext;
        end
    end

    // ------------------------------------------------------------------
    // Handshake: request register feeds the result register.
    // ------------------------------------------------------------------
    logic              in_valid_reg;
    logic              in_kind_reg;
    logic [DATA_W-1:0] in_key_reg;
    logic [DATA_W-1:0] in_value_reg;

    logic              out_valid_reg;
    logic              out_found_reg;
    logic              out_from_ram_reg;
    logic [DATA_W-1:0] out_const_reg;

    logic advance;
    logic process;

    assign advance = !out_valid_reg || m_ready;
    assign process = advance && in_valid_reg;
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_kind_reg  <= s_kind;
            in_key_reg   <= s_lookup_key;
            in_value_reg <= s_store_value;
        end
    end

    // ------------------------------------------------------------------
    // Slot state: keys, valid bits and recency ranks in flip-flops so that
    // every slot is compared in parallel. Rank 0 is the most recent.
    // ------------------------------------------------------------------
    logic [DATA_W-1:0] key_reg    [ENTRIES];
    logic [DATA_W-1:0] key_next   [ENTRIES];
    logic [ENTRIES-1:0] valid_reg;
    logic [ENTRIES-1:0] valid_next;
    logic [IDX_W-1:0]  rank_reg   [ENTRIES];
    logic [IDX_W-1:0]  rank_next  [ENTRIES];

    logic [ENTRIES-1:0] match_vec;
    logic [ENTRIES-1:0] evict_vec;
    logic [ENTRIES-1:0] kept_vec;
    logic [ENTRIES-1:0] rank0_vec;
    logic               hit;
    logic [IDX_W-1:0]   hit_idx;
    logic [IDX_W-1:0]   hit_rank;
    logic               free_found;
    logic [IDX_W-1:0]   free_idx;
    logic               is_put;

    assign is_put = (in_kind_reg == KIND_PUT);

    // Key compare, eviction marks and one-hot to binary encode of the hit.
    always_comb begin
        hit_idx  = '0;
        hit_rank = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            match_vec[i] = valid_reg[i] && (key_reg[i] == in_key_reg);
            // A put miss keeps only entries younger than capacity - 1, so
            // that the new entry brings occupancy up to capacity at most.
            evict_vec[i] = valid_reg[i] && (CW'(rank_reg[i]) >= (eff_cap - CW'(1)));
            kept_vec[i]  = valid_reg[i] && !evict_vec[i];
            rank0_vec[i] = valid_reg[i] && (rank_reg[i] == '0);
            if (match_vec[i]) begin
                hit_idx  = hit_idx | IDX_W'(i);
                hit_rank = hit_rank | rank_reg[i];
            end
        end
    end

    assign hit = |match_vec;

    // Lowest-numbered slot that is free once eviction has taken place.
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (!kept_vec[i]) begin
                free_found = 1'b1;
                free_idx   = IDX_W'(i);
            end
        end
    end

    // Next slot state for the request being processed.
    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            key_next[i]   = key_reg[i];
            valid_next[i] = valid_reg[i];
            rank_next[i]  = rank_reg[i];
            if (process) begin
                if (hit) begin
                    // Touch: younger entries age by one, the hit becomes newest.
                    if (match_vec[i]) begin
                        rank_next[i] = '0;
                    end else if (valid_reg[i] && (rank_reg[i] < hit_rank)) begin
                        rank_next[i] = rank_reg[i] + IDX_W'(1);
                    end
                end else if (is_put) begin
                    if (free_found && (free_idx == IDX_W'(i))) begin
                        valid_next[i] = 1'b1;
                        rank_next[i]  = '0;
                        key_next[i]   = in_key_reg;
                    end else if (kept_vec[i]) begin
                        rank_next[i]  = rank_reg[i] + IDX_W'(1);
                    end else begin
                        valid_next[i] = 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            for (int i = 0; i < ENTRIES; i++) begin
                rank_reg[i] <= '0;
            end
        end else begin
            valid_reg <= valid_next;
            for (int i = 0; i < ENTRIES; i++) begin
                rank_reg[i] <= rank_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < ENTRIES; i++) begin
            key_reg[i] <= key_next[i];
        end
    end

    // ------------------------------------------------------------------
    // Value memory. A put writes the hit slot or the newly filled slot; a
    // get hit reads the hit slot into the memory's output register, which
    // then stands as the result value until the result word is taken.
    // ------------------------------------------------------------------
    logic              ram_wr_en;
    logic [IDX_W-1:0]  ram_wr_addr;
    logic              ram_rd_en;
    logic [DATA_W-1:0] ram_rd_data;

    assign ram_wr_en   = process && is_put && (hit || free_found);
    assign ram_wr_addr = hit ? hit_idx : free_idx;
    assign ram_rd_en   = process && !is_put && hit;

    lkvc_ram #(
        .WIDTH (DATA_W),
        .DEPTH (ENTRIES)
    ) u_value_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (in_value_reg),
        .rd_en   (ram_rd_en),
        .rd_addr (hit_idx),
        .rd_data (ram_rd_data)
    );

    // ------------------------------------------------------------------
    // Result register.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (process) begin
            out_found_reg    <= hit;
            out_from_ram_reg <= !is_put && hit;
            out_const_reg    <= is_put ? PUT_VALUE : MISS_VALUE;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_found      = out_found_reg;
    assign m_read_value = out_from_ram_reg ? ram_rd_data : out_const_reg;

`ifndef SYNTHESIS
    // Stored keys stay distinct, so a lookup matches one slot at most.
    a_single_match: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(match_vec))
        else $error("more than one slot matches the key");

    // A non-empty cache has exactly one most recent entry.
    a_one_newest: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg != '0) |-> $onehot(rank0_vec))
        else $error("most recent entry is not unique");

    // Eviction always leaves a slot for a put miss.
    a_free_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        (process && is_put && !hit) |-> free_found)
        else $error("no free slot for a new entry");

    // A get hit shows its value from the memory in the next result word.
    a_get_hit_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (process && !is_put && hit) |=> (out_valid_reg && out_from_ram_reg && out_found_reg))
        else $error("get hit result not taken from value memory");

    // The request side only stalls while both registers are full and blocked.
    a_ready_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid_reg && out_valid_reg && !m_ready))
        else $error("request side stalled without cause");
`endif

endmodule

[hw/rtl/lkvc_ram.sv]
// ============================================================================
// lkvc_ram : generic single-write, single-read RAM
// One write port and one read port; read data is registered on read enable.
// ============================================================================
module lkvc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                     aclk,
    input  logic                                     wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                         wr_data,
    input  logic                                     rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[bench/lru_key_value_cache_tb.sv]
`timescale 1ns / 100ps
// ============================================================================
// lru_key_value_cache_tb : self-checking bench for the LRU key/value cache
// Sends get and put request words with random gaps, keeps its own cache image
// to predict every result word, and compares each received result, field by
// field, against the oldest prediction. Capacity is rewritten between phases,
// including the clamped values zero and above the slot count.
// ============================================================================
module lru_key_value_cache_tb;
    import lkvc_pkg::*;

    localparam int SLOTS       = 16;
    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_REPORTS = 10;

    // One predicted result word.
    typedef struct packed {
        logic              found;
        logic [DATA_W-1:0] value;
    } lookup_result_t;

    logic                     aclk          = 1'b0;
    logic                     aresetn       = 1'b0;
    logic                     cfg_wr_en     = 1'b0;
    logic [CFG_W-1:0]         cfg_wr_data   = '0;
    logic                     s_valid       = 1'b0;
    logic                     s_ready;
    logic                     s_kind        = 1'b0;
    logic signed [DATA_W-1:0] s_lookup_key  = '0;
    logic signed [DATA_W-1:0] s_store_value = '0;
    logic                     m_valid;
    logic                     m_ready       = 1'b0;
    logic                     m_found;
    logic signed [DATA_W-1:0] m_read_value;

    // Shadow image of the cache. Ages run 0 (newest) up to occupancy-1.
    logic [DATA_W-1:0] slot_key  [SLOTS];
    logic [DATA_W-1:0] slot_data [SLOTS];
    logic              slot_live [SLOTS];
    int unsigned       slot_age  [SLOTS];
    int unsigned       live_count;
    logic [CFG_W-1:0]  cap_setting;

    lookup_result_t pending_results [$];
    int             fail_count   = 0;
    int             result_count = 0;
    int             cycle_count  = 0;
    // Chance in percent that a word on either side is preceded by an idle
    // burst. Zero means both sides run at full rate.
    int             idle_odds    = 0;
    int             stall_left   = 0;

    lru_key_value_cache #(
        .ENTRIES(SLOTS)
    ) i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_kind       (s_kind),
        .s_lookup_key (s_lookup_key),
        .s_store_value(s_store_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_found      (m_found),
        .m_read_value (m_read_value)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Hard stop in case a word is lost or the handshake hangs.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Cache image
    // ------------------------------------------------------------------------

    function automatic int find_slot(input logic [DATA_W-1:0] key);
        for (int i = 0; i < SLOTS; i++)
            if (slot_live[i] && slot_key[i] == key)
                return i;
        return -1;
    endfunction

    // Moves a slot to the front; only the entries that were newer age by one.
    function automatic void make_newest(input int s);
        int unsigned old_age;
        old_age = slot_age[s];
        for (int i = 0; i < SLOTS; i++)
            if (slot_live[i] && slot_age[i] < old_age)
                slot_age[i]++;
        slot_age[s] = 0;
    endfunction

    // Applies one request to the image and returns the result word it causes.
    function automatic lookup_result_t apply_request(input kind_t kind,
                                                     input logic [DATA_W-1:0] key,
                                                     input logic [DATA_W-1:0] data);
        lookup_result_t res;
        int             s;
        int             victim;
        int             free_slot;
        int unsigned    limit;
        s = find_slot(key);
        res.found = (s >= 0);
        if (kind == KIND_GET) begin
            // A miss leaves the recency order alone.
            if (s >= 0) begin
                make_newest(s);
                res.value = slot_data[s];
            end else begin
                res.value = MISS_VALUE;
            end
            return res;
        end
        res.value = PUT_VALUE;
        if (s >= 0) begin
            slot_data[s] = data;
            make_newest(s);
            return res;
        end
        // The capacity is clamped to 1..SLOTS. After a shrink the occupancy may
        // sit above it, so evict the oldest until there is room for one more.
        if (cap_setting == 0)
            limit = 1;
        else if (cap_setting > SLOTS)
            limit = SLOTS;
        else
            limit = cap_setting;
        while (live_count >= limit && live_count > 0) begin
            victim = -1;
            for (int i = 0; i < SLOTS; i++)
                if (victim < 0 && slot_live[i] && slot_age[i] == live_count - 1)
                    victim = i;
            if (victim < 0)
                break;
            slot_live[victim] = 1'b0;
            slot_age[victim]  = 0;
            live_count--;
        end
        // The new pair takes the lowest free slot; everything else ages.
        free_slot = -1;
        for (int i = 0; i < SLOTS; i++) begin
            if (!slot_live[i]) begin
                if (free_slot < 0)
                    free_slot = i;
            end else begin
                slot_age[i]++;
            end
        end
        if (free_slot >= 0) begin
            slot_live[free_slot] = 1'b1;
            slot_key[free_slot]  = key;
            slot_data[free_slot] = data;
            slot_age[free_slot]  = 0;
            live_count++;
        end
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Result side: random stall bursts on m_ready and the word checker.
    // ------------------------------------------------------------------------

    always @(posedge aclk) begin
        lookup_result_t want;
        if (aresetn && m_valid && m_ready) begin
            result_count++;
            if (pending_results.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("word %0d arrived with nothing expected: found=%0b value=%h",
                             result_count, m_found, m_read_value);
            end else begin
                want = pending_results.pop_front();
                if (m_found !== want.found || m_read_value !== want.value) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("word %0d: expected found=%0b value=%h, got found=%0b value=%h",
                                 result_count, want.found, want.value, m_found, m_read_value);
                end
            end
        end
        // A stall burst holds m_ready low; its length is drawn at random when it starts.
        if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (idle_odds != 0 && $urandom_range(1, 100) <= idle_odds) begin
            stall_left = $urandom_range(1, 17) - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------

    // Presents one request word, holds it until accepted, and records the
    // predicted result. Called and returning right after a rising edge.
    task automatic send_request(input kind_t kind, input logic [DATA_W-1:0] key,
                                input logic [DATA_W-1:0] data);
        int gap;
        if (idle_odds != 0 && $urandom_range(1, 100) <= idle_odds) begin
            gap = $urandom_range(1, 17);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_kind        <= kind;
        s_lookup_key  <= key;
        s_store_value <= data;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        pending_results.push_back(apply_request(kind, key, data));
    endtask

    // Writes the capacity once the block has drained every outstanding word.
    task automatic set_capacity(input logic [CFG_W-1:0] value);
        s_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (3) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        cap_setting = value;
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Key and value extremes at the reset capacity, starting from empty.
    task automatic test_field_extremes();
        idle_odds = 10;
        send_request(KIND_GET, 32'h8000_0000, 32'h1234_5678);
        send_request(KIND_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
        send_request(KIND_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
        send_request(KIND_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
        send_request(KIND_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
        send_request(KIND_GET, 32'h8000_0000, 32'h0000_0000);
        send_request(KIND_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(KIND_PUT, 32'h8000_0000, 32'h5555_5555);
        send_request(KIND_GET, 32'h8000_0000, 32'hAAAA_AAAA);
        send_request(KIND_GET, 32'h0000_0001, 32'h0000_0000);
    endtask

    // A capacity of zero behaves as one: each new key pushes out the last.
    task automatic test_capacity_zero();
        set_capacity(5'd0);
        send_request(KIND_PUT, 32'h1234_5678, 32'hAAAA_AAAA);
        send_request(KIND_PUT, 32'h9ABC_DEF0, 32'h5555_5555);
        send_request(KIND_GET, 32'h1234_5678, 32'h0000_0000);
        send_request(KIND_GET, 32'h9ABC_DEF0, 32'h0000_0000);
    endtask

    // Capacity above the slot count, then lowered below the occupancy. Only
    // a put of an absent key may evict, and then down to one below capacity.
    task automatic test_capacity_shrink();
        set_capacity(5'd31);
        send_request(KIND_PUT, 32'h0000_00A1, 32'h0000_0001);
        send_request(KIND_PUT, 32'h0000_00A2, 32'h0000_0002);
        send_request(KIND_PUT, 32'h0000_00A3, 32'h0000_0003);
        send_request(KIND_GET, 32'h9ABC_DEF0, 32'h0000_0000);
        set_capacity(5'd2);
        send_request(KIND_PUT, 32'h9ABC_DEF0, 32'h0F0F_0F0F);
        send_request(KIND_PUT, 32'h0000_00A4, 32'h0000_0004);
        send_request(KIND_GET, 32'h0000_00A1, 32'h0000_0000);
        send_request(KIND_GET, 32'h9ABC_DEF0, 32'h0000_0000);
    endtask

    // Random gets and puts over a key pool a little larger than the capacity,
    // so that hits, misses, updates and evictions all keep happening.
    task automatic test_random_traffic(input logic [CFG_W-1:0] cap, input int count,
                                       input int odds);
        logic [DATA_W-1:0] key_pool [$];
        logic [DATA_W-1:0] key;
        logic [DATA_W-1:0] data;
        kind_t             kind;
        int                pool_len;
        set_capacity(cap);
        idle_odds = odds;
        pool_len = (cap == 0) ? 1 : (cap > SLOTS) ? SLOTS : int'(cap);
        pool_len += $urandom_range(1, 6);
        key_pool.push_back(32'h8000_0000);
        key_pool.push_back(32'h7FFF_FFFF);
        while (key_pool.size() < pool_len)
            key_pool.push_back($urandom);
        for (int n = 0; n < count; n++) begin
            kind = kind_t'($urandom_range(0, 1));
            // A few keys from outside the pool give plain misses.
            if ($urandom_range(0, 15) == 0)
                key = $urandom;
            else
                key = key_pool[$urandom_range(0, pool_len - 1)];
            case ($urandom_range(0, 7))
                0:       data = '0;
                1:       data = '1;
                default: data = $urandom;
            endcase
            send_request(kind, key, data);
        end
    endtask

    initial begin
        for (int i = 0; i < SLOTS; i++) begin
            slot_live[i] = 1'b0;
            slot_age[i]  = 0;
        end
        live_count  = 0;
        cap_setting = CAP_RESET;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        test_field_extremes();
        test_capacity_zero();
        test_capacity_shrink();

        // Several capacity settings, each with its own amount of idling.
        test_random_traffic(5'd16, 140, 15);
        test_random_traffic(5'd1,  140, 30);
        test_random_traffic(5'd31, 140, 0);
        test_random_traffic(5'd0,  140, 5);
        test_random_traffic(5'd5,  140, 20);
        test_random_traffic(5'd17, 140, 10);
        test_random_traffic(5'd3,  140, 30);
        test_random_traffic(5'($urandom_range(0, 31)), 140, 15);
        // Full rate on both sides to close the run.
        test_random_traffic(CAP_RESET, 130, 0);

        s_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
